// ===== sv/qcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_pkg
// Widths, request codes, control types and the micro-op table shared by the
// quaternion compose and rotate unit.
// ----------------------------------------------------------------------------
package qcr_pkg;

  // Quaternion components are Q2.14, points Q16.16.
  localparam int QUAT_WIDTH    = 16;
  localparam int POINT_WIDTH   = 32;
  localparam int QFRAC         = QUAT_WIDTH - 2;
  localparam int PROD_WIDTH    = QUAT_WIDTH + POINT_WIDTH;
  localparam int ACC_WIDTH     = PROD_WIDTH + 4;
  localparam int MAT_N         = 9;
  localparam int MAT_IDX_W     = 4;
  localparam int STEP_W        = 5;
  localparam int COMPOSE_STEPS = 16;
  localparam int ROTATE_STEPS  = 27;

  localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(64'd1 << QFRAC);
  localparam logic signed [ACC_WIDTH-1:0] ACC_ONE  = ACC_WIDTH'(64'd1 << (2 * QFRAC));
  localparam logic signed [ACC_WIDTH-1:0] ACC_HALF = ACC_WIDTH'(64'd1 << (QFRAC - 1));

  // Request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_COMPOSE = 2'd1;
  localparam logic [1:0] REQ_ROTATE  = 2'd2;

  // Multiplier operand sources
  typedef enum logic [0:0] {A_QUAT, A_MAT}   a_src_e;
  typedef enum logic [0:0] {B_QS,   B_POINT} b_src_e;

  // One multiply-accumulate micro-op
  typedef struct packed {
    logic                 vld;
    a_src_e               a_src;
    logic [MAT_IDX_W-1:0] a_idx;
    b_src_e               b_src;
    logic [1:0]           b_idx;
    logic                 neg;
    logic                 dbl;
    logic                 first;
    logic                 one;
    logic                 last;
    logic                 dst_img;
    logic [MAT_IDX_W-1:0] dst_idx;
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_q;
    logic cap_arg;
    logic cap_self;
    logic cap_point;
    logic clr_flag;
    logic commit;
    logic out_load;
    cmd_t cmd;
  } ctl_t;

  function automatic cmd_t mk_cmd(a_src_e as, int ai, b_src_e bs, int bi, int ng, int db,
                                  int fi, int on, int la, int di, int dx);
    cmd_t c;
    c.vld     = 1'b1;
    c.a_src   = as;
    c.a_idx   = MAT_IDX_W'(ai);
    c.b_src   = bs;
    c.b_idx   = 2'(bi);
    c.neg     = 1'(ng);
    c.dbl     = 1'(db);
    c.first   = 1'(fi);
    c.one     = 1'(on);
    c.last    = 1'(la);
    c.dst_img = 1'(di);
    c.dst_idx = MAT_IDX_W'(dx);
    return c;
  endfunction

  // Compose term: stored component a times supplied component b
  function automatic cmd_t cmp_op(int ai, int bi, int ng, int fi, int la, int dx);
    return mk_cmd(A_QUAT, ai, B_QS, bi, ng, 0, fi, 0, la, 0, dx);
  endfunction

  // Matrix term: twice the product of two stored components
  function automatic cmd_t mat_op(int ai, int bi, int ng, int fi, int on, int la, int dx);
    return mk_cmd(A_QUAT, ai, B_QS, bi, ng, 1, fi, on, la, 0, dx);
  endfunction

  // Image term: matrix entry times point coordinate
  function automatic cmd_t img_op(int ai, int bi, int dx);
    return mk_cmd(A_MAT, ai, B_POINT, bi, 0, 0, (bi == 0) ? 1 : 0, 0, (bi == 2) ? 1 : 0,
                  1, dx);
  endfunction

  // Micro-op sequence for compose (rot = 0) and rotate (rot = 1)
  function automatic cmd_t cmd_rom(logic rot, logic [STEP_W-1:0] step);
    cmd_t c;
    c = '0;
    if (!rot) begin
      unique case (step)
        5'd0:    c = cmp_op(0, 0, 0, 1, 0, 0);
        5'd1:    c = cmp_op(1, 1, 1, 0, 0, 0);
        5'd2:    c = cmp_op(2, 2, 1, 0, 0, 0);
        5'd3:    c = cmp_op(3, 3, 1, 0, 1, 0);
        5'd4:    c = cmp_op(1, 0, 0, 1, 0, 1);
        5'd5:    c = cmp_op(0, 1, 0, 0, 0, 1);
        5'd6:    c = cmp_op(3, 2, 0, 0, 0, 1);
        5'd7:    c = cmp_op(2, 3, 1, 0, 1, 1);
        5'd8:    c = cmp_op(2, 0, 0, 1, 0, 2);
        5'd9:    c = cmp_op(0, 2, 0, 0, 0, 2);
        5'd10:   c = cmp_op(3, 1, 1, 0, 0, 2);
        5'd11:   c = cmp_op(1, 3, 0, 0, 1, 2);
        5'd12:   c = cmp_op(3, 0, 0, 1, 0, 3);
        5'd13:   c = cmp_op(0, 3, 0, 0, 0, 3);
        5'd14:   c = cmp_op(2, 1, 0, 0, 0, 3);
        5'd15:   c = cmp_op(1, 2, 1, 0, 1, 3);
        default: c = '0;
      endcase
    end else begin
      unique case (step)
        5'd0:    c = mat_op(2, 2, 1, 1, 1, 0, 0);
        5'd1:    c = mat_op(3, 3, 1, 0, 0, 1, 0);
        5'd2:    c = mat_op(1, 2, 0, 1, 0, 0, 1);
        5'd3:    c = mat_op(0, 3, 1, 0, 0, 1, 1);
        5'd4:    c = mat_op(0, 2, 0, 1, 0, 0, 2);
        5'd5:    c = mat_op(1, 3, 0, 0, 0, 1, 2);
        5'd6:    c = mat_op(0, 3, 0, 1, 0, 0, 3);
        5'd7:    c = mat_op(1, 2, 0, 0, 0, 1, 3);
        5'd8:    c = mat_op(1, 1, 1, 1, 1, 0, 4);
        5'd9:    c = mat_op(3, 3, 1, 0, 0, 1, 4);
        5'd10:   c = mat_op(2, 3, 0, 1, 0, 0, 5);
        5'd11:   c = mat_op(0, 1, 1, 0, 0, 1, 5);
        5'd12:   c = mat_op(1, 3, 0, 1, 0, 0, 6);
        5'd13:   c = mat_op(0, 2, 1, 0, 0, 1, 6);
        5'd14:   c = mat_op(0, 1, 0, 1, 0, 0, 7);
        5'd15:   c = mat_op(2, 3, 0, 0, 0, 1, 7);
        5'd16:   c = mat_op(1, 1, 1, 1, 1, 0, 8);
        5'd17:   c = mat_op(2, 2, 1, 0, 0, 1, 8);
        5'd18:   c = img_op(0, 0, 0);
        5'd19:   c = img_op(1, 1, 0);
        5'd20:   c = img_op(2, 2, 0);
        5'd21:   c = img_op(3, 0, 1);
        5'd22:   c = img_op(4, 1, 1);
        5'd23:   c = img_op(5, 2, 1);
        5'd24:   c = img_op(6, 0, 2);
        5'd25:   c = img_op(7, 1, 2);
        5'd26:   c = img_op(8, 2, 2);
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== sv/qcr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_req_if
// Request channel: request type, supplied quaternion and point.
// ----------------------------------------------------------------------------
interface qcr_req_if;
  import qcr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [QUAT_WIDTH-1:0]  arg_w;
  logic signed [QUAT_WIDTH-1:0]  arg_x;
  logic signed [QUAT_WIDTH-1:0]  arg_y;
  logic signed [QUAT_WIDTH-1:0]  arg_z;
  logic signed [POINT_WIDTH-1:0] point_x;
  logic signed [POINT_WIDTH-1:0] point_y;
  logic signed [POINT_WIDTH-1:0] point_z;

  modport source (
    output valid, req_type, arg_w, arg_x, arg_y, arg_z, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, arg_w, arg_x, arg_y, arg_z, point_x, point_y, point_z,
    output ready
  );
endinterface

// ===== sv/qcr_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_res_if
// Result channel: rotated point and saturation flag.
// ----------------------------------------------------------------------------
interface qcr_res_if;
  import qcr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [POINT_WIDTH-1:0] image_x;
  logic signed [POINT_WIDTH-1:0] image_y;
  logic signed [POINT_WIDTH-1:0] image_z;
  logic                          saturated;

  modport source (
    output valid, image_x, image_y, image_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, image_x, image_y, image_z, saturated,
    output ready
  );
endinterface

// ===== sv/quaternion_compose_and_rotate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_compose_and_rotate_unit
// Holds one Q2.14 orientation quaternion, reset to (0, 1, 0, 0). A load
// request replaces it; a compose request replaces it with the Hamilton
// product of the supplied quaternion times the stored one; a rotate request
// builds the rotation matrix and applies it to a Q16.16 point, and may wait
// for the output register to free. Both run on a single shared 16 x 32
// signed multiplier issuing one product per cycle (16 products for compose,
// 27 for rotate) followed by a three-stage multiply, accumulate and
// round/saturate pipe. Only rotate gives a result; its saturation flag is
// set if any matrix entry or image coordinate was clipped. No normalization
// is done. A new request is taken while a result still waits in the output
// register.
// ----------------------------------------------------------------------------
module quaternion_compose_and_rotate_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  qcr_req_if.sink    req_i,
  qcr_res_if.source  res_o
);
  import qcr_pkg::*;

  ctl_t ctl;

  qcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .ctl_o       (ctl)
  );

  qcr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .arg_w_i     (req_i.arg_w),
    .arg_x_i     (req_i.arg_x),
    .arg_y_i     (req_i.arg_y),
    .arg_z_i     (req_i.arg_z),
    .point_x_i   (req_i.point_x),
    .point_y_i   (req_i.point_y),
    .point_z_i   (req_i.point_z),
    .image_x_o   (res_o.image_x),
    .image_y_o   (res_o.image_y),
    .image_z_o   (res_o.image_z),
    .saturated_o (res_o.saturated)
  );

endmodule

// ===== sv/qcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_ctrl
// Controller: accepts requests, steps through the micro-op table, waits for
// the accumulator pipe to drain and hands results to the output register.
// ----------------------------------------------------------------------------
module qcr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_type_i,
  output logic          req_ready_o,
  input  logic          res_ready_i,
  output logic          res_valid_o,
  output qcr_pkg::ctl_t ctl_o
);
  import qcr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              rot_q, rot_d;
  logic              out_valid_q, out_valid_d;
  logic [STEP_W-1:0] last_step;

  assign last_step   = rot_q ? STEP_W'(ROTATE_STEPS - 1) : STEP_W'(COMPOSE_STEPS - 1);
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rot_d   = rot_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (req_type_i)
            REQ_LOAD: begin
              ctl_o.load_q = 1'b1;
            end
            REQ_COMPOSE: begin
              ctl_o.cap_arg = 1'b1;
              rot_d         = 1'b0;
              step_d        = '0;
              state_d       = S_RUN;
            end
            REQ_ROTATE: begin
              ctl_o.cap_self  = 1'b1;
              ctl_o.cap_point = 1'b1;
              ctl_o.clr_flag  = 1'b1;
              rot_d           = 1'b1;
              step_d          = '0;
              state_d         = S_RUN;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      S_RUN: begin
        ctl_o.cmd = cmd_rom(rot_q, step_q);
        if (step_q == last_step) begin
          step_d  = '0;
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // wait for the product and accumulate stages
        if (step_q == STEP_W'(1)) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!rot_q) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (!out_valid_q || res_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/qcr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_dp
// Datapath: orientation store, operand registers, one shared signed
// multiplier, accumulator, round/saturate writeback and output register.
// ----------------------------------------------------------------------------
module qcr_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  qcr_pkg::ctl_t                          ctl_i,
  input  logic signed [qcr_pkg::QUAT_WIDTH-1:0]  arg_w_i,
  input  logic signed [qcr_pkg::QUAT_WIDTH-1:0]  arg_x_i,
  input  logic signed [qcr_pkg::QUAT_WIDTH-1:0]  arg_y_i,
  input  logic signed [qcr_pkg::QUAT_WIDTH-1:0]  arg_z_i,
  input  logic signed [qcr_pkg::POINT_WIDTH-1:0] point_x_i,
  input  logic signed [qcr_pkg::POINT_WIDTH-1:0] point_y_i,
  input  logic signed [qcr_pkg::POINT_WIDTH-1:0] point_z_i,
  output logic signed [qcr_pkg::POINT_WIDTH-1:0] image_x_o,
  output logic signed [qcr_pkg::POINT_WIDTH-1:0] image_y_o,
  output logic signed [qcr_pkg::POINT_WIDTH-1:0] image_z_o,
  output logic                                   saturated_o
);
  import qcr_pkg::*;

  logic signed [QUAT_WIDTH-1:0]  q_q [4];     // orientation
  logic signed [QUAT_WIDTH-1:0]  s_q [4];     // supplied or copied quaternion
  logic signed [POINT_WIDTH-1:0] p_q [3];
  logic signed [QUAT_WIDTH-1:0]  d_q [MAT_N]; // matrix entries / new quaternion
  logic signed [POINT_WIDTH-1:0] img_q [3];
  logic                          flag_q;

  logic signed [QUAT_WIDTH-1:0]  a_op;
  logic signed [POINT_WIDTH-1:0] b_op;
  logic signed [PROD_WIDTH-1:0]  prod_d, prod_q;
  cmd_t                          c1_q, c2_q;
  logic signed [ACC_WIDTH-1:0]   acc_q, acc_d, base, term;
  logic signed [ACC_WIDTH-1:0]   rnd;
  logic [ACC_WIDTH-QUAT_WIDTH:0]  hi_q16;
  logic [ACC_WIDTH-POINT_WIDTH:0] hi_p32;
  logic                          ovf_q16, ovf_p32;
  logic signed [QUAT_WIDTH-1:0]  sat_q16;
  logic signed [POINT_WIDTH-1:0] sat_p32;
  logic signed [POINT_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic                          out_sat_q;

  // Operand select
  always_comb begin
    unique case (ctl_i.cmd.a_src)
      A_QUAT:  a_op = q_q[ctl_i.cmd.a_idx[1:0]];
      A_MAT:   a_op = d_q[ctl_i.cmd.a_idx];
      default: a_op = '0;
    endcase
    unique case (ctl_i.cmd.b_src)
      B_QS:    b_op = POINT_WIDTH'(s_q[ctl_i.cmd.b_idx]);
      B_POINT: b_op = p_q[ctl_i.cmd.b_idx];
      default: b_op = '0;
    endcase
  end

  assign prod_d = PROD_WIDTH'(a_op) * PROD_WIDTH'(b_op);

  // Accumulate stage
  always_comb begin
    term = ACC_WIDTH'(prod_q);
    if (c1_q.dbl) begin
      term = term <<< 1;
    end
    if (c1_q.first) begin
      base = c1_q.one ? ACC_ONE : '0;
    end else begin
      base = acc_q;
    end
    acc_d = c1_q.neg ? (base - term) : (base + term);
  end

  // Round half up, then saturate to both widths
  always_comb begin
    rnd     = (acc_q + ACC_HALF) >>> QFRAC;
    hi_q16  = rnd[ACC_WIDTH-1:QUAT_WIDTH-1];
    hi_p32  = rnd[ACC_WIDTH-1:POINT_WIDTH-1];
    ovf_q16 = !((&hi_q16) || !(|hi_q16));
    ovf_p32 = !((&hi_p32) || !(|hi_p32));
    if (ovf_q16) begin
      sat_q16 = rnd[ACC_WIDTH-1] ? {1'b1, {(QUAT_WIDTH-1){1'b0}}}
                                 : {1'b0, {(QUAT_WIDTH-1){1'b1}}};
    end else begin
      sat_q16 = rnd[QUAT_WIDTH-1:0];
    end
    if (ovf_p32) begin
      sat_p32 = rnd[ACC_WIDTH-1] ? {1'b1, {(POINT_WIDTH-1){1'b0}}}
                                 : {1'b0, {(POINT_WIDTH-1){1'b1}}};
    end else begin
      sat_p32 = rnd[POINT_WIDTH-1:0];
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else begin
      c1_q <= ctl_i.cmd;
      c2_q <= c1_q;
    end
  end

  // Product and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (c1_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // Orientation store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= '0;
      q_q[1] <= QUAT_ONE;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else if (ctl_i.load_q) begin
      q_q[0] <= arg_w_i;
      q_q[1] <= arg_x_i;
      q_q[2] <= arg_y_i;
      q_q[3] <= arg_z_i;
    end else if (ctl_i.commit) begin
      q_q[0] <= d_q[0];
      q_q[1] <= d_q[1];
      q_q[2] <= d_q[2];
      q_q[3] <= d_q[3];
    end
  end

  // Operand capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_arg) begin
      s_q[0] <= arg_w_i;
      s_q[1] <= arg_x_i;
      s_q[2] <= arg_y_i;
      s_q[3] <= arg_z_i;
    end else if (ctl_i.cap_self) begin
      s_q[0] <= q_q[0];
      s_q[1] <= q_q[1];
      s_q[2] <= q_q[2];
      s_q[3] <= q_q[3];
    end
    if (ctl_i.cap_point) begin
      p_q[0] <= point_x_i;
      p_q[1] <= point_y_i;
      p_q[2] <= point_z_i;
    end
  end

  // Writeback of finished sums
  always_ff @(posedge clk_i) begin
    if (c2_q.vld && c2_q.last) begin
      if (c2_q.dst_img) begin
        img_q[c2_q.dst_idx[1:0]] <= sat_p32;
      end else begin
        d_q[c2_q.dst_idx] <= sat_q16;
      end
    end
  end

  // Saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (ctl_i.clr_flag) begin
      flag_q <= 1'b0;
    end else if (c2_q.vld && c2_q.last) begin
      if (c2_q.dst_img ? ovf_p32 : ovf_q16) begin
        flag_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_x_q   <= img_q[0];
      out_y_q   <= img_q[1];
      out_z_q   <= img_q[2];
      out_sat_q <= flag_q;
    end
  end

  assign image_x_o   = out_x_q;
  assign image_y_o   = out_y_q;
  assign image_z_o   = out_z_q;
  assign saturated_o = out_sat_q;

endmodule
